[rtl/constant_weight_encoder_core_defines.svh]
// Assertion macros for the constant-weight encoder.
// Used by any RTL file that asserts; needs clk and arst_n in scope.
`ifndef CONSTANT_WEIGHT_ENCODER_CORE_DEFINES_SVH
`define CONSTANT_WEIGHT_ENCODER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define CWE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define CWE_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CWE_ASSERT(label, prop, msg)
`define CWE_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

[rtl/cwe_pkg.sv]
// Shared types, constants and the binomial row builder of the encoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package cwe_pkg;
	localparam int MaxLength = 64;
	localparam int WordW     = 64;
	localparam int CfgW      = 7;
	localparam int PosW      = $clog2(MaxLength);

	typedef enum logic {
		REG_WEIGHT      = 1'b0,
		REG_CODE_LENGTH = 1'b1
	} reg_idx_t;

	typedef logic [WordW-1:0] coef_row_t [0:(1<<CfgW)-1];

	typedef struct packed {
		logic [WordW-1:0] rem;
		logic [CfgW-1:0]  wgt;
		logic [CfgW-1:0]  len;
		logic [WordW-1:0] word;
	} stage_data_t;

	// Row n of the Pascal triangle, zero beyond k = n
	function automatic coef_row_t binom_row(input int n);
		coef_row_t c;
		for (int k = 0; k < (1 << CfgW); k++) begin
			c[k] = '0;
		end
		c[0] = WordW'(1);
		for (int i = 1; i <= n; i++) begin
			for (int k = i; k >= 1; k--) begin
				c[k] = c[k] + c[k-1];
			end
		end
		return c;
	endfunction
endpackage
`default_nettype wire

[rtl/cwe_ifs.sv]
// Stream interfaces: input value channel and codeword result channel.
// Depends on cwe_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface cwe_value_if;
	logic                              valid;
	logic                              ready;
	logic signed [cwe_pkg::WordW-1:0]  value;
	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

interface cwe_code_if;
	logic                        valid;
	logic                        ready;
	logic [cwe_pkg::WordW-1:0]   codeword;
	modport source (output valid, output codeword, input ready);
	modport sink (input valid, input codeword, output ready);
endinterface
`default_nettype wire

[rtl/constant_weight_encoder_core.sv]
// Top level of the constant-weight encoder: config registers and 64-stage walk.
// Depends on cwe_pkg, cwe_ifs, cwe_stage and the assertion macro header.
//
//  channel   | dir | payload            | handshake
//  ----------+-----+--------------------+-------------
//  value_ch  | in  | value  (s64)       | valid/ready
//  code_ch   | out | codeword (u64)     | valid/ready
//  cfg       | in  | cfg_index, cfg_data| cfg_we
//
// One item per cycle while code_ch.ready holds; one pipeline stage per codeword
// position, 63 down to 0; the last stage register is the output register.
// Each stage holds its own valid bit and takes a new item when empty or
// when its successor moves, so bubbles close up under a stall.
// Reset clears valid bits but not stage data; weight resets to 1, code_length to 64.
`include "constant_weight_encoder_core_defines.svh"
`timescale 1ns / 1ps
`default_nettype none
module constant_weight_encoder_core (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire cwe_pkg::reg_idx_t         cfg_index,
	input  wire logic [cwe_pkg::CfgW-1:0]  cfg_data,
	cwe_value_if.sink                      value_ch,
	cwe_code_if.source                     code_ch
);
	import cwe_pkg::*;

	logic [CfgW-1:0] weight_q;
	logic [CfgW-1:0] code_length_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q      <= CfgW'(1);
			code_length_q <= CfgW'(MaxLength);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WEIGHT:      weight_q      <= cfg_data;
				REG_CODE_LENGTH: code_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// vld[i], rdy[i] and dat[i] feed the stage for position MaxLength-1-i
	logic        vld   [0:MaxLength];
	logic        rdy   [0:MaxLength];
	stage_data_t dat   [0:MaxLength];

	// entry: saturate length, a negative value walks with zero weight
	always_comb begin
		dat[0].rem  = value_ch.value;
		dat[0].wgt  = value_ch.value[WordW-1] ? '0 : weight_q;
		dat[0].len  = (code_length_q > CfgW'(MaxLength)) ? CfgW'(MaxLength)
		                                                  : code_length_q;
		dat[0].word = '0;
	end
	assign vld[0]         = value_ch.valid;
	assign value_ch.ready = rdy[0];

	for (genvar i = 0; i < MaxLength; i++) begin : g_pos
		localparam int P = MaxLength - 1 - i;
		localparam coef_row_t Row = binom_row(P);
		cwe_stage u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.pos      (PosW'(P)),
			.coef     (Row),
			.up_valid (vld[i]),
			.up_data  (dat[i]),
			.up_ready (rdy[i]),
			.dn_valid (vld[i+1]),
			.dn_data  (dat[i+1]),
			.dn_ready (rdy[i+1])
		);
	end

	assign code_ch.valid    = vld[MaxLength];
	assign code_ch.codeword = dat[MaxLength].word;
	assign rdy[MaxLength]   = code_ch.ready;

	// never more ones than the weight
	`CWE_ASSERT(a_weight_bound, code_ch.valid |-> ($countones(code_ch.codeword) <= weight_q), "codeword over weight")
	// nothing set at or above the length
	`CWE_ASSERT(a_len_bound, code_ch.valid |-> ((code_ch.codeword >> dat[MaxLength].len) == '0), "bit beyond length")
	// an empty output stage leaves the whole chain open
	`CWE_ASSERT(a_open_chain, !code_ch.valid |-> value_ch.ready, "input blocked with empty output")
endmodule
`default_nettype wire

[rtl/cwe_stage.sv]
// One codeword position of the greedy walk, with its pipeline register.
// Depends on cwe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cwe_stage (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [cwe_pkg::PosW-1:0]   pos,
	input  wire cwe_pkg::coef_row_t         coef,
	input  wire logic                       up_valid,
	input  wire cwe_pkg::stage_data_t       up_data,
	output logic                            up_ready,
	output logic                            dn_valid,
	output cwe_pkg::stage_data_t            dn_data,
	input  wire logic                       dn_ready
);
	import cwe_pkg::*;

	logic        valid_q;
	stage_data_t data_q;
	stage_data_t nxt;
	logic        active;
	logic        pos_ge_w;
	logic [WordW-1:0] thr;

	always_comb begin
		nxt      = up_data;
		active   = ({1'b0, pos} < up_data.len) && (up_data.wgt != '0);
		pos_ge_w = {1'b0, pos} >= up_data.wgt;
		thr      = coef[up_data.wgt];
		if (active) begin
			if (!pos_ge_w) begin
				nxt.word[pos] = 1'b1;
				nxt.wgt       = up_data.wgt - 1'b1;
			end else if (up_data.rem >= thr) begin
				nxt.word[pos] = 1'b1;
				nxt.rem       = up_data.rem - thr;
				nxt.wgt       = up_data.wgt - 1'b1;
			end
		end
	end

	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q <= nxt;
		end
	end

	assign dn_valid = valid_q;
	assign dn_data  = data_q;
endmodule
`default_nettype wire
